>>> rtl/core/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants of the 3x3 sharpen block: request structs,
// register indexes, field widths and the stage-one control group.
// ----------------------------------------------------------------------------
package shp_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int HEIGHT_LIMIT   = 4096;

    localparam int PIX_IO_BITS   = 16;
    localparam int SIZE_BITS     = 13;
    localparam int CLIP_BITS     = 16;
    localparam int ROW_BITS      = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEVEL   = 2'd2;

    localparam logic ACT_PIXEL = 1'b0;

    typedef struct packed {
        logic                   action;
        logic [PIX_IO_BITS-1:0] pixel_in;
    } t_in_req;

    typedef struct packed {
        logic [PIX_IO_BITS-1:0] pixel_out;
        logic                   frame_end;
    } t_out_req;

    typedef struct packed {
        logic is_pixel;
        logic emit;
        logic border;
        logic use_win;
        logic frame_end;
        logic mem_ok;
    } t_s1_ctl;

endpackage

>>> rtl/core/shp_ram.sv
// ----------------------------------------------------------------------------
// shp_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module shp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/shp_ctrl.sv
// ----------------------------------------------------------------------------
// shp_ctrl
// Configuration registers, raster and output position counters, line
// buffer fill count and the stage-one request register.
// ----------------------------------------------------------------------------
module shp_ctrl #(
    parameter int MAX_WIDTH  = shp_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = shp_pkg::PIXEL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [shp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [shp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_accept,
    input  shp_pkg::t_in_req                   i_in_req,
    input  logic                               i_s1_en,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_rd_addr,
    output logic                               o_s1_valid,
    output shp_pkg::t_s1_ctl                   o_s1_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_s1_addr,
    output logic [PIXEL_BITS-1:0]              o_s1_pix,
    output logic [PIXEL_BITS-1:0]              o_clip_lim
);

    import shp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);

    logic [SIZE_BITS-1:0] r_frame_width, n_frame_width;
    logic [SIZE_BITS-1:0] r_frame_height, n_frame_height;
    logic [CLIP_BITS-1:0] r_clip_level, n_clip_level;

    logic [CW-1:0]       r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [CW-1:0]       r_ecol, n_ecol;
    logic [ROW_BITS-1:0] r_erow, n_erow;
    logic [WB-1:0]       r_fill, n_fill;

    logic                  r_s1_valid;
    t_s1_ctl               r_s1_ctl;
    logic [CW-1:0]         r_s1_addr;
    logic [PIXEL_BITS-1:0] r_s1_pix;

    logic [WB-1:0]       w_eff, w_m1, col_nx, ecol_nx;
    logic [ROW_BITS-1:0] h_eff, h_m1;
    logic                s0_go;
    t_s1_ctl             s0_ctl;
    logic [CW-1:0]       s0_addr;

    always_comb begin
        if (r_frame_width < SIZE_BITS'(3)) begin
            w_eff = WB'(3);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_frame_width);
        end
        if (r_frame_height < SIZE_BITS'(3)) begin
            h_eff = ROW_BITS'(3);
        end else if (32'(r_frame_height) > 32'(HEIGHT_LIMIT)) begin
            h_eff = ROW_BITS'(HEIGHT_LIMIT);
        end else begin
            h_eff = ROW_BITS'(r_frame_height);
        end
        w_m1 = w_eff - WB'(1);
        h_m1 = h_eff - ROW_BITS'(1);
        col_nx = WB'(r_col) + WB'(1);
        ecol_nx = WB'(r_ecol) + WB'(1);
    end

    always_comb begin
        if (32'(r_clip_level) > ((32'd1 << PIXEL_BITS) - 32'd1)) begin
            o_clip_lim = '1;
        end else begin
            o_clip_lim = PIXEL_BITS'(r_clip_level);
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ecol = r_ecol;
        n_erow = r_erow;
        n_fill = r_fill;
        n_frame_width = r_frame_width;
        n_frame_height = r_frame_height;
        n_clip_level = r_clip_level;
        s0_go = 1'b0;
        s0_ctl = '0;
        s0_addr = r_col;

        if (i_accept) begin
            if (r_row >= h_eff) begin
                // tail of the frame: border pixels from the buffers
                s0_go = 1'b1;
                s0_ctl.emit = 1'b1;
                s0_ctl.use_win = (r_erow != h_m1);
                s0_ctl.frame_end = (r_erow == h_m1) && (WB'(r_ecol) == w_m1);
                s0_ctl.mem_ok = (WB'(r_ecol) < r_fill);
                s0_addr = r_ecol;
                if (s0_ctl.frame_end) begin
                    n_col = '0;
                    n_row = '0;
                    n_ecol = '0;
                    n_erow = '0;
                end else if (ecol_nx >= w_eff) begin
                    n_ecol = '0;
                    n_erow = r_erow + ROW_BITS'(1);
                end else begin
                    n_ecol = CW'(ecol_nx);
                end
            end else if (i_in_req.action == ACT_PIXEL) begin
                s0_go = 1'b1;
                s0_ctl.is_pixel = 1'b1;
                s0_ctl.mem_ok = (WB'(r_col) < r_fill);
                s0_ctl.emit = (r_row >= ROW_BITS'(2))
                           || ((r_row == ROW_BITS'(1)) && (r_col != '0));
                s0_ctl.border = (r_erow == '0) || (r_erow >= h_m1)
                             || (r_ecol == '0) || (WB'(r_ecol) >= w_m1);
                if (s0_ctl.emit) begin
                    if (ecol_nx >= w_eff) begin
                        n_ecol = '0;
                        n_erow = r_erow + ROW_BITS'(1);
                    end else begin
                        n_ecol = CW'(ecol_nx);
                    end
                end
                if (col_nx > r_fill) begin
                    n_fill = col_nx;
                end
                if (col_nx >= w_eff) begin
                    n_col = '0;
                    n_row = r_row + ROW_BITS'(1);
                end else begin
                    n_col = CW'(col_nx);
                end
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH: begin
                    n_frame_width = SIZE_BITS'(i_cfg_data);
                    n_col = '0;
                    n_row = '0;
                    n_ecol = '0;
                    n_erow = '0;
                end
                REG_FRAME_HEIGHT: begin
                    n_frame_height = SIZE_BITS'(i_cfg_data);
                    n_col = '0;
                    n_row = '0;
                    n_ecol = '0;
                    n_erow = '0;
                end
                REG_CLIP_LEVEL: begin
                    n_clip_level = CLIP_BITS'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= SIZE_BITS'(4096);
            r_frame_height <= SIZE_BITS'(4096);
            r_clip_level <= CLIP_BITS'(65535);
            r_col <= '0;
            r_row <= '0;
            r_ecol <= '0;
            r_erow <= '0;
            r_fill <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_frame_width <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_clip_level <= n_clip_level;
            r_col <= n_col;
            r_row <= n_row;
            r_ecol <= n_ecol;
            r_erow <= n_erow;
            r_fill <= n_fill;
            if (i_s1_en) begin
                r_s1_valid <= s0_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_en) begin
            r_s1_ctl <= s0_ctl;
            r_s1_addr <= s0_addr;
            r_s1_pix <= i_in_req.pixel_in[PIXEL_BITS-1:0];
        end
    end

    assign o_rd_addr = s0_addr;
    assign o_s1_valid = r_s1_valid;
    assign o_s1_ctl = r_s1_ctl;
    assign o_s1_addr = r_s1_addr;
    assign o_s1_pix = r_s1_pix;

endmodule

>>> rtl/core/shp_dp.sv
// ----------------------------------------------------------------------------
// shp_dp
// Datapath: line buffer write-back, neighborhood window, Laplacian sum,
// saturation and the output register, with per-stage flow control.
// ----------------------------------------------------------------------------
module shp_dp #(
    parameter int MAX_WIDTH  = shp_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = shp_pkg::PIXEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  shp_pkg::t_s1_ctl              i_s1_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_s1_addr,
    input  logic [PIXEL_BITS-1:0]         i_s1_pix,
    input  logic [2*PIXEL_BITS-1:0]       i_rd_data,
    input  logic [PIXEL_BITS-1:0]         i_clip_lim,
    input  logic                          i_out_ready,
    output logic                          o_s1_en,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_wr_addr,
    output logic [2*PIXEL_BITS-1:0]       o_wr_data,
    output logic                          o_out_valid,
    output shp_pkg::t_out_req             o_out_req
);

    import shp_pkg::*;

    localparam int SW = PIXEL_BITS + 4;

    logic [PIXEL_BITS-1:0] r_win0, r_win1, r_win2, r_win4;

    logic                  r_s2_valid;
    logic                  r_s2_sharp;
    logic                  r_s2_end;
    logic [PIXEL_BITS-1:0] r_s2_pass;
    logic signed [SW-1:0]  r_s2_sum;

    logic                  r_o_valid;
    logic [PIXEL_BITS-1:0] r_o_pix;
    logic                  r_o_end;

    logic                  en_out, en2, s1_go;
    logic [PIXEL_BITS-1:0] top, mid, pass, clamped;
    logic signed [SW-1:0]  sum, lim_s;

    assign en_out = !r_o_valid || i_out_ready;
    assign en2 = !r_s2_valid || en_out;
    assign o_s1_en = !i_s1_valid || en2;
    assign s1_go = i_s1_valid && en2;

    always_comb begin
        top = i_s1_ctl.mem_ok ? i_rd_data[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
        mid = i_s1_ctl.mem_ok ? i_rd_data[PIXEL_BITS-1:0] : '0;
        pass = (i_s1_ctl.is_pixel || i_s1_ctl.use_win) ? r_win1 : mid;
        sum = $signed(SW'(r_win1) << 2) + $signed(SW'(r_win1))
            - $signed(SW'(r_win0)) - $signed(SW'(r_win2))
            - $signed(SW'(r_win4)) - $signed(SW'(mid));
    end

    assign o_wr_en = s1_go && i_s1_ctl.is_pixel;
    assign o_wr_addr = i_s1_addr;
    assign o_wr_data = {mid, i_s1_pix};

    always_comb begin
        lim_s = $signed(SW'(i_clip_lim));
        if (r_s2_sum < 0) begin
            clamped = '0;
        end else if (r_s2_sum >= lim_s) begin
            clamped = i_clip_lim;
        end else begin
            clamped = r_s2_sum[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
            r_win2 <= '0;
            r_win4 <= '0;
            r_s2_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s1_go && i_s1_ctl.is_pixel) begin
                r_win4 <= r_win1;
                r_win0 <= top;
                r_win1 <= mid;
                r_win2 <= i_s1_pix;
            end
            if (en2) begin
                r_s2_valid <= s1_go && i_s1_ctl.emit;
            end
            if (en_out) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_sharp <= i_s1_ctl.is_pixel && !i_s1_ctl.border;
            r_s2_end <= i_s1_ctl.frame_end;
            r_s2_pass <= pass;
            r_s2_sum <= sum;
        end
        if (en_out) begin
            r_o_pix <= r_s2_sharp ? clamped : r_s2_pass;
            r_o_end <= r_s2_end;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_req.pixel_out = PIX_IO_BITS'(r_o_pix);
    assign o_out_req.frame_end = r_o_end;

endmodule

>>> rtl/core/sharpen_3x3_saturating.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_saturating
// Streaming 3x3 Laplacian sharpen of raster-order grayscale frames.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless stalled and delivers at most
// one result per clock; each result passes the s1, s2 and output registers
// and lags the input by one image row plus one pixel. Interior pixels become
// 5*center minus the four direct neighbors, clamped to zero and to the clip
// level; border pixels pass through. After the last pixel of a frame, flush
// requests (or further pixels, which are dropped) push out the remaining row
// plus one pixel, the last one marked with frame_end. Both previous rows live
// in one line buffer RAM, read once and written once per pixel; a fill count
// makes columns never written since reset read as zero, so no clearing pass
// is needed. Writing frame_width or frame_height restarts the frame; the user
// must write configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module sharpen_3x3_saturating #(
    parameter int MAX_WIDTH  = shp_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = shp_pkg::PIXEL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  shp_pkg::t_in_req                   i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output shp_pkg::t_out_req                  o_out_req,
    input  logic                               i_cfg_we,
    input  logic [shp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [shp_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    import shp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic                    accept;
    logic                    s1_en;
    logic [CW-1:0]           rd_addr;
    logic                    s1_valid;
    t_s1_ctl                 s1_ctl;
    logic [CW-1:0]           s1_addr;
    logic [PIXEL_BITS-1:0]   s1_pix;
    logic [PIXEL_BITS-1:0]   clip_lim;
    logic [2*PIXEL_BITS-1:0] rd_data;
    logic                    wr_en;
    logic [CW-1:0]           wr_addr;
    logic [2*PIXEL_BITS-1:0] wr_data;

    assign o_in_ready = s1_en;
    assign accept = i_in_valid && s1_en;

    shp_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_accept  (accept),
        .i_in_req  (i_in_req),
        .i_s1_en   (s1_en),
        .o_rd_addr (rd_addr),
        .o_s1_valid(s1_valid),
        .o_s1_ctl  (s1_ctl),
        .o_s1_addr (s1_addr),
        .o_s1_pix  (s1_pix),
        .o_clip_lim(clip_lim)
    );

    shp_ram #(
        .WIDTH(2 * PIXEL_BITS),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (s1_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    shp_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1_ctl   (s1_ctl),
        .i_s1_addr  (s1_addr),
        .i_s1_pix   (s1_pix),
        .i_rd_data  (rd_data),
        .i_clip_lim (clip_lim),
        .i_out_ready(i_out_ready),
        .o_s1_en    (s1_en),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_out_valid(o_out_valid),
        .o_out_req  (o_out_req)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 3x3 sharpen block. A local copy of
// the line buffers, window and frame counters predicts every output pixel;
// results are checked in order against it under random idling, a long
// output hold-off, clamped frame sizes and a cut-short tallest frame.
// ----------------------------------------------------------------------------
module testbench;
    import shp_pkg::*;

    localparam int          LINE_DEPTH   = MAX_WIDTH_DEF;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic        ACT_FLUSH    = 1'b1;
    localparam logic [15:0] PIX_MAX      = 16'hFFFF;

    typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_BAND} t_pix_style;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    t_in_req                  in_req    = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    t_out_req                 out_req;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    logic        holding = 1'b0;
    event        hold_ev;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned requests_sent  = 0;
    int unsigned pixels_checked = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;

    // predictor state
    logic [15:0]          upper_row [LINE_DEPTH];
    logic [15:0]          middle_row [LINE_DEPTH];
    logic [15:0]          win [6];
    int unsigned          col_pos, row_pos, out_pos;
    logic [SIZE_BITS-1:0] width_reg, height_reg;
    logic [CLIP_BITS-1:0] clip_reg;
    t_out_req             pending_pixels [$];

    sharpen_3x3_saturating u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_req   (out_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void rewind_frame();
        col_pos = 0;
        row_pos = 0;
        out_pos = 0;
    endfunction

    function automatic void sharpen_predict(input t_in_req req);
        int unsigned w, h, c, n, er, ec, total, k;
        logic [15:0] mid;
        int          sum;
        t_out_req    r;
        w = clamp_size(width_reg, LINE_DEPTH);
        h = clamp_size(height_reg, HEIGHT_LIMIT);
        if (row_pos >= h) begin
            // tail of the frame: any request pushes out one border pixel
            total = w * h;
            k = out_pos - (total - w - 1);
            if (k == 0)
                r.pixel_out = win[1];
            else if (k - 1 < LINE_DEPTH)
                r.pixel_out = middle_row[k - 1];
            else
                r.pixel_out = '0;
            out_pos++;
            r.frame_end = (out_pos >= total);
            if (r.frame_end)
                rewind_frame();
            pending_pixels.push_back(r);
        end else if (req.action == ACT_PIXEL) begin
            c = (col_pos >= w) ? w - 1 : col_pos;
            mid = middle_row[c];
            n = row_pos * w + c;
            if (n >= w + 1) begin
                er = out_pos / w;
                ec = out_pos % w;
                if (er == 0 || er >= h - 1 || ec == 0 || ec >= w - 1) begin
                    r.pixel_out = win[1];
                end else begin
                    sum = 5 * int'(win[1]) - int'(win[0]) - int'(win[2])
                        - int'(win[4]) - int'(mid);
                    if (sum < 0)
                        r.pixel_out = '0;
                    else if (sum >= int'(clip_reg))
                        r.pixel_out = clip_reg;
                    else
                        r.pixel_out = sum[15:0];
                end
                r.frame_end = 1'b0;
                out_pos++;
                pending_pixels.push_back(r);
            end
            win[3] = win[0];
            win[4] = win[1];
            win[5] = win[2];
            win[0] = upper_row[c];
            win[1] = mid;
            win[2] = req.pixel_in;
            upper_row[c]  = mid;
            middle_row[c] = req.pixel_in;
            col_pos = c + 1;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
        end
    endfunction

    function automatic void flag_error(input string what, input int unsigned want,
                                       input int unsigned got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch %s: expected %0h, got %0h (result %0d)",
                     what, want, got, pixels_checked);
    endfunction

    // output side: random stalls plus the long hold-off
    always @(posedge i_clk) begin
        out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    always begin
        @(hold_ev);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    always @(posedge i_clk) begin : check_results
        t_out_req want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                flag_error("unexpected result", 0, out_req);
            end else begin
                want = pending_pixels.pop_front();
                if (out_req.pixel_out !== want.pixel_out)
                    flag_error("pixel_out", want.pixel_out, out_req.pixel_out);
                if (out_req.frame_end !== want.frame_end)
                    flag_error("frame_end", want.frame_end, out_req.frame_end);
                pixels_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_req(input logic act, input logic [15:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= {act, pix};
        do @(posedge i_clk); while (!in_ready);
        sharpen_predict(in_req);
        requests_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH: begin
                width_reg = data[SIZE_BITS-1:0];
                rewind_frame();
            end
            REG_FRAME_HEIGHT: begin
                height_reg = data[SIZE_BITS-1:0];
                rewind_frame();
            end
            REG_CLIP_LEVEL: begin
                clip_reg = data[CLIP_BITS-1:0];
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] clip);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CLIP_LEVEL, clip);
    endtask

    // one frame at the current sizes; cut_at stops early without a tail
    task automatic run_frame(input t_pix_style style, input int unsigned noise_pct,
                             input int unsigned cut_at);
        int unsigned w, h, n;
        logic [15:0] base, pix;
        w = clamp_size(width_reg, LINE_DEPTH);
        h = clamp_size(height_reg, HEIGHT_LIMIT);
        n = (cut_at != 0) ? cut_at : w * h;
        base = 16'($urandom_range(16'hFEFF));
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct)
                send_req(ACT_FLUSH, 16'($urandom));
            case (style)
                PIX_UNIFORM: pix = 16'($urandom);
                PIX_EXTREME: pix = $urandom_range(1) ? PIX_MAX : 16'h0000;
                default:     pix = base + 16'($urandom_range(255));
            endcase
            send_req(ACT_PIXEL, pix);
        end
        if (cut_at == 0) begin
            for (int unsigned i = 0; i <= w; i++)
                send_req(($urandom_range(99) < 80) ? ACT_FLUSH : ACT_PIXEL, 16'($urandom));
        end
    endtask

    task automatic directed_frame(input logic [15:0] center, input logic [15:0] ring);
        send_req(ACT_FLUSH, ring);
        for (int i = 0; i < 9; i++)
            send_req(ACT_PIXEL, (i == 4) ? center : ring);
        send_req(ACT_PIXEL, center);
        repeat (3) send_req(ACT_FLUSH, ring);
    endtask

    task automatic test_reset();
        i_rst_n <= 1'b0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        width_reg  = 13'd4096;
        height_reg = 13'd4096;
        clip_reg   = PIX_MAX;
        rewind_frame();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed_extremes();
        // upper size bits are dropped, leaving 3x3
        write_reg(REG_FRAME_WIDTH, 16'hE003);
        write_reg(REG_FRAME_HEIGHT, 16'hE003);
        directed_frame(PIX_MAX, 16'h0000);
        drain();
        write_reg(REG_CLIP_LEVEL, 16'd1000);
        directed_frame(16'h0000, PIX_MAX);
    endtask

    task automatic test_size_clamping();
        configure(16'h0000, 16'h0002, 16'($urandom));
        run_frame(PIX_EXTREME, 10, 0);
        configure(16'h0001, 16'h0000, 16'h0000);
        run_frame(PIX_UNIFORM, 10, 0);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(16'd8, 16'd6, 16'($urandom));
        -> hold_ev;
        run_frame(PIX_UNIFORM, 0, 0);
        run_frame(PIX_BAND, 0, 0);
    endtask

    task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned quota);
        int unsigned start, w, h, frames;
        logic [15:0] clip;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = requests_sent;
        while (requests_sent - start < quota) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            case ($urandom_range(3))
                0:       clip = PIX_MAX;
                1:       clip = 16'h0000;
                2:       clip = 16'($urandom_range(4095));
                default: clip = 16'($urandom);
            endcase
            configure(16'(w), 16'(h), clip);
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                if ($urandom_range(99) < 8) begin
                    // broken frame: abandon it and restart through the width register
                    run_frame(t_pix_style'($urandom_range(2)), 10,
                              $urandom_range(1, w * h - 1));
                    drain();
                    write_reg(REG_FRAME_WIDTH, 16'(w));
                end else begin
                    run_frame(t_pix_style'($urandom_range(2)), 5, 0);
                end
            end
        end
    endtask

    task automatic test_tallest_frame();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(16'h0002, 16'hFFFF, PIX_MAX);
        run_frame(PIX_BAND, 0, 150);
    endtask

    initial begin
        test_reset();
        test_directed_extremes();
        test_size_clamping();
        test_random_phase(0, 0, 250);
        test_random_phase(66, 0, 250);
        test_random_phase(0, 66, 250);
        test_random_phase(12, 12, 250);
        test_backpressure();
        test_tallest_frame();
        drain();
        repeat (20) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            flag_error("results missing", pending_pixels.size(), 0);
        $display("sent %0d requests and checked %0d pixels over frames from 3x3 to 40x8",
                 requests_sent, pixels_checked);
        $display("plus the top of a 3x4096 frame, clip levels 0 to 65535, idle and stall phases");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
